FILE: sv/key_matrix_event_tracker_macros.svh
// Assertion macros for the key matrix event tracker.
// Used by key_matrix_event_tracker.sv; expects i_clk and i_rst_n in scope.
`ifndef KEY_MATRIX_EVENT_TRACKER_MACROS_SVH
`define KEY_MATRIX_EVENT_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define KMET_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("kmet assertion failed");

// Checked on every edge, reset included.
`define KMET_ASSERT_NORST(name, prop) \
    name: assert property (@(posedge i_clk) prop) \
        else $error("kmet reset assertion failed");

`else

`define KMET_ASSERT(name, prop)
`define KMET_ASSERT_NORST(name, prop)

`endif

`endif

FILE: sv/kmet_pkg.sv
// Package for the key matrix event tracker: widths, reset values, codes, types.
// No dependencies; imported by key_matrix_event_tracker and the testbench.
`default_nettype none

package kmet_pkg;

    localparam int ROWS_DEF   = 6;
    localparam int COLS_DEF   = 10;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 4;
    localparam int TIME_W     = 32;
    localparam int REQ_W      = 2;
    localparam int CODE_W     = 8;
    localparam int NOTE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Raw code layout: press flag on top, key number plus one below.
    localparam int PRESS_BIT  = 7;
    localparam int KEY_BASE   = 10;
    // k / 10 == (k * 205) >> 11 for k < 1029
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;

    localparam logic [TIME_W-1:0] HOLD_TO_RST  = 32'd30000;
    localparam logic [TIME_W-1:0] FAST_TO_RST  = 32'd3000;
    localparam logic [TIME_W-1:0] FAST_WIN_RST = 32'd5000;
    localparam logic [NOTE_W-1:0] NOTE_ROWS_RST = 3'd0;

    typedef enum logic [REQ_W-1:0] {
        REQ_EVENT   = 2'd0,
        REQ_POLL    = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD   = 2'd0,
        CFG_FAST   = 2'd1,
        CFG_WINDOW = 2'd2,
        CFG_NOTE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVENT,
        ST_PREP,
        ST_SEEN,
        ST_TMO,
        ST_CLEAR,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic              held;
        logic              seen;
        logic              dir;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             pressed;
        logic             note;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/key_matrix_event_tracker.sv
// Key matrix event tracker: per-key state in one synchronous memory, swept by a
// read-modify-write pipeline. Depends on kmet_pkg and key_matrix_event_tracker_macros.svh.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one request transaction at a time:
//   a raw key code, a poll end (time and overflow flag) or a release-all.
//   Output channel (o_out_valid/i_out_ready) carries key changes; o_last marks
//   the final change caused by a request. Key events and empty windows give none.
//   Configuration (i_cfg_we/i_cfg_idx/i_cfg_data) must be written only while idle; the
//   block itself does not enforce this. A key event reads its entry, then writes it back.
//   A poll end makes two passes over the key memory, first the seen pass, then the
//   timeout pass, one key per cycle each unless the receiver stalls, set by the
//   single memory read port. A release-all makes one pass; an unknown request is dropped.
//   Each result waits in a holding register until the next one is found or the
//   request ends, so the final one carries o_last. The next request is taken
//   while that last result still waits in the output register.
//   Receiver stall: the pass pauses on a key that has a result while both the output
//   register and the holding register are full; nothing is dropped.
//   Reset: synchronous; clears all keys (per-entry valid bits), the overflow
//   state, the output channel, and loads configuration defaults.
`default_nettype none
`include "key_matrix_event_tracker_macros.svh"

module key_matrix_event_tracker
    import kmet_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [REQ_W-1:0]      i_req_type,
    input  wire logic [CODE_W-1:0]     i_key_code,
    input  wire logic [TIME_W-1:0]     i_now_ms,
    input  wire logic                  i_overflow,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [ROW_W-1:0]           o_out_row,
    output logic [COL_W-1:0]           o_out_col,
    output logic                       o_out_pressed,
    output logic                       o_note_key,
    output logic                       o_last,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NKEYS = ROWS * COLS;
    localparam int KEY_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NKEYS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
    localparam logic [3:0]       ROW_LIM  = 4'(ROWS);
    localparam logic [6:0]       COL_LIM  = 7'(COLS);

    // configuration
    logic [TIME_W-1:0] r_hold_to, r_fast_to, r_fast_win;
    logic [NOTE_W-1:0] r_note_rows;

    // request context
    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_now;
    logic              r_ovf_hap;
    logic [TIME_W-1:0] r_ovf_stamp;
    logic [TIME_W-1:0] r_timeout;
    logic [KEY_W-1:0]  r_ev_idx;
    logic              r_ev_dir;

    // key memory
    t_entry            mem [NKEYS];
    t_entry            r_rdata;
    logic              r_rd_vld;
    logic [NKEYS-1:0]  r_vld;

    // sweep pipeline
    logic [KEY_W-1:0]  r_iss_idx, r_s1_idx;
    logic [ROW_W-1:0]  r_iss_row, r_s1_row;
    logic [COL_W-1:0]  r_iss_col, r_s1_col;
    logic              r_iss_done, r_s1_v;

    // result holding and output registers
    t_result           r_hold, r_out;
    logic              r_hold_v, r_out_v;

    // combinational
    logic              in_acc, out_take, out_free, out_load;
    logic              mem_re, mem_we, iss, proc, stall, flush, ctr_clr;
    logic [KEY_W-1:0]  raddr, waddr;
    t_entry            wdata, ent;
    t_result           res;
    logic              res_v;
    logic [TIME_W-1:0] elapsed;
    logic              recent;

    // raw code decode
    logic [6:0]        dec_num, dec_k, dec_col;
    logic [14:0]       dec_prod, dec_quo;
    logic [3:0]        dec_row;
    logic [7:0]        dec_idx8;
    logic              dec_ok;
    logic [KEY_W-1:0]  ev_idx;

    always_comb begin
        dec_num  = i_key_code[6:0];
        dec_k    = dec_num - 7'd1;
        dec_prod = {8'd0, dec_k} * 15'(DIV10_MUL);
        dec_quo  = dec_prod >> DIV10_SHIFT;
        dec_row  = dec_quo[3:0];
        dec_col  = dec_k - 7'({3'd0, dec_row} * 7'(KEY_BASE));
        dec_ok   = (dec_num != 7'd0) && (dec_row < ROW_LIM) && (dec_col < COL_LIM);
        dec_idx8 = {4'd0, dec_row} * 8'(COLS) + {1'b0, dec_col};
        ev_idx   = dec_idx8[KEY_W-1:0];
    end

    assign ent      = r_rd_vld ? r_rdata : '0;
    assign elapsed  = r_now - ent.stamp;
    assign recent   = r_ovf_hap && ((r_now - r_ovf_stamp) < r_fast_win);
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_take = r_out_v && i_out_ready;
    assign out_free = !r_out_v || i_out_ready;
    assign out_load = (proc && res_v && r_hold_v) || flush;

    // next state, memory control, pass results
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        raddr      = r_iss_idx;
        waddr      = r_s1_idx;
        wdata      = ent;
        res        = '0;
        res.row    = r_s1_row;
        res.col    = r_s1_col;
        res_v      = 1'b0;
        stall      = 1'b0;
        iss        = 1'b0;
        proc       = 1'b0;
        flush      = 1'b0;
        ctr_clr    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ctr_clr    = i_in_valid;
                if (i_in_valid) begin
                    case (t_req'(i_req_type))
                        REQ_EVENT: begin
                            if (dec_ok) begin
                                mem_re  = 1'b1;
                                raddr   = ev_idx;
                                n_state = ST_EVENT;
                            end
                        end
                        REQ_POLL:    n_state = ST_PREP;
                        REQ_RELEASE: n_state = ST_CLEAR;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EVENT: begin
                mem_we     = 1'b1;
                waddr      = r_ev_idx;
                wdata.seen = 1'b1;
                wdata.dir  = r_ev_dir;
                n_state    = ST_IDLE;
            end
            ST_PREP: n_state = ST_SEEN;
            ST_SEEN, ST_TMO, ST_CLEAR: begin
                if (r_state == ST_SEEN) begin
                    wdata.seen = 1'b0;
                    res.note   = (r_s1_row < r_note_rows);
                    if (ent.seen && ent.dir && !ent.held) begin
                        wdata.held  = 1'b1;
                        wdata.stamp = r_now;
                        res.pressed = 1'b1;
                        res_v       = r_s1_v;
                    end else if (ent.seen && !ent.dir && ent.held) begin
                        wdata.held = 1'b0;
                        res_v      = r_s1_v;
                    end
                end else if (r_state == ST_TMO) begin
                    if (ent.held && (elapsed > r_timeout)) begin
                        wdata.held = 1'b0;
                        res_v      = r_s1_v;
                    end
                end else begin
                    wdata.held  = 1'b0;
                    wdata.stamp = '0;
                    res_v       = r_s1_v && ent.held;
                end
                stall  = r_s1_v && res_v && r_hold_v && !out_free;
                proc   = r_s1_v && !stall;
                iss    = !r_iss_done && !stall;
                mem_re = iss;
                mem_we = proc;
                if (r_iss_done && !r_s1_v) begin
                    if (r_state == ST_SEEN) begin
                        ctr_clr = 1'b1;
                        n_state = ST_TMO;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_hold_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    flush   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and overflow state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_to   <= HOLD_TO_RST;
            r_fast_to   <= FAST_TO_RST;
            r_fast_win  <= FAST_WIN_RST;
            r_note_rows <= NOTE_ROWS_RST;
            r_ovf_hap   <= 1'b0;
            r_ovf_stamp <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HOLD:   r_hold_to   <= i_cfg_data;
                    CFG_FAST:   r_fast_to   <= i_cfg_data;
                    CFG_WINDOW: r_fast_win  <= i_cfg_data;
                    CFG_NOTE:   r_note_rows <= i_cfg_data[NOTE_W-1:0];
                    default:    r_hold_to   <= r_hold_to;
                endcase
            end
            if (in_acc && (t_req'(i_req_type) == REQ_POLL) && i_overflow) begin
                r_ovf_hap   <= 1'b1;
                r_ovf_stamp <= i_now_ms;
            end
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now    <= i_now_ms;
            r_ev_idx <= ev_idx;
            r_ev_dir <= i_key_code[PRESS_BIT];
        end
        if (r_state == ST_PREP) begin
            r_timeout <= recent ? r_fast_to : r_hold_to;
        end
    end

    // key memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[waddr] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_vld <= r_vld[raddr];
            end
        end
    end

    // sweep counters and read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_done <= 1'b0;
            r_s1_v     <= 1'b0;
        end else begin
            if (ctr_clr) begin
                r_iss_done <= 1'b0;
            end else if (iss) begin
                r_iss_done <= (r_iss_idx == LAST_KEY);
            end
            r_s1_v <= iss || (r_s1_v && stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctr_clr) begin
            r_iss_idx <= '0;
            r_iss_row <= '0;
            r_iss_col <= '0;
        end else if (iss) begin
            r_iss_idx <= r_iss_idx + KEY_W'(1);
            if (r_iss_col == LAST_COL) begin
                r_iss_col <= '0;
                r_iss_row <= r_iss_row + ROW_W'(1);
            end else begin
                r_iss_col <= r_iss_col + COL_W'(1);
            end
        end
        if (iss) begin
            r_s1_idx <= r_iss_idx;
            r_s1_row <= r_iss_row;
            r_s1_col <= r_iss_col;
        end
    end

    // results: one held back so the final one can carry the last flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (proc && res_v) begin
                r_hold_v <= 1'b1;
            end else if (flush) begin
                r_hold_v <= 1'b0;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (out_take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res_v) begin
            r_hold <= res;
        end
        if (out_load) begin
            r_out <= '{row: r_hold.row, col: r_hold.col, pressed: r_hold.pressed,
                       note: r_hold.note, last: flush};
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_out_row     = r_out.row;
    assign o_out_col     = r_out.col;
    assign o_out_pressed = r_out.pressed;
    assign o_note_key    = r_out.note;
    assign o_last        = r_out.last;

    `KMET_ASSERT(a_idle_hold_empty, (r_state == ST_IDLE) |-> !r_hold_v)
    `KMET_ASSERT(a_ready_no_inflight, o_in_ready |-> !r_s1_v)
    `KMET_ASSERT(a_no_rw_collision, (mem_we && mem_re) |-> (waddr != raddr))
    `KMET_ASSERT_NORST(a_reset_idle, !i_rst_n |=> ((r_state == ST_IDLE) && !o_out_valid))

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for key_matrix_event_tracker: directed script, then random phases.
// Keeps its own key-state predictor; needs kmet_pkg and the tracker RTL.
`default_nettype none

module testbench;
    import kmet_pkg::*;

    localparam int KEYS           = ROWS_DEF * COLS_DEF;
    localparam int SETTLE_CYCLES  = 2 * KEYS + 40;
    localparam int HOLD_OFF       = 600;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        t_req              req;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] now;
        logic              ovf;
    } t_kbd_request;

    typedef struct packed {
        t_kbd_request rq;
        logic         typed;
        logic         has_change;
        t_result      change;
    } t_script_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [REQ_W-1:0]      i_req_type;
    logic [CODE_W-1:0]     i_key_code;
    logic [TIME_W-1:0]     i_now_ms;
    logic                  i_overflow;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [ROW_W-1:0]      o_out_row;
    logic [COL_W-1:0]      o_out_col;
    logic                  o_out_pressed;
    logic                  o_note_key;
    logic                  o_last;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    key_matrix_event_tracker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_key_code    (i_key_code),
        .i_now_ms      (i_now_ms),
        .i_overflow    (i_overflow),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_out_pressed (o_out_pressed),
        .o_note_key    (o_note_key),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    bit              key_down    [KEYS];
    bit [TIME_W-1:0] down_since  [KEYS];
    bit              touched     [KEYS];
    bit              last_dir    [KEYS];
    bit              overflow_flag;
    bit [TIME_W-1:0] overflow_ms;
    bit [TIME_W-1:0] hold_ms;
    bit [TIME_W-1:0] fast_ms;
    bit [TIME_W-1:0] window_ms;
    bit [NOTE_W-1:0] note_limit;

    t_result         step_changes[$];
    t_result         pending_changes[$];
    t_script_row     script[27];

    bit              steady;
    bit              hold_off_pending;
    bit [TIME_W-1:0] wall_ms;
    int              mismatches;
    int              requests_sent;
    int              changes_checked;
    int              settings_seen;
    int              quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function automatic void note_change(int r, int c, bit pressed, bit note);
        t_result ch;
        ch.row     = ROW_W'(r);
        ch.col     = COL_W'(c);
        ch.pressed = pressed;
        ch.note    = note;
        ch.last    = 1'b0;
        step_changes.push_back(ch);
    endfunction

    task automatic predict_changes(input t_kbd_request rq);
        int              k;
        int              i;
        bit              fast;
        bit [TIME_W-1:0] limit;
        bit [TIME_W-1:0] held_for;
        bit [TIME_W-1:0] since_ovf;
        step_changes.delete();
        case (rq.req)
            REQ_EVENT: begin
                k = int'(rq.code[6:0]) - 1;
                if (k >= 0 && k / KEY_BASE < ROWS_DEF && k % KEY_BASE < COLS_DEF) begin
                    i = (k / KEY_BASE) * COLS_DEF + k % KEY_BASE;
                    touched[i]  = 1'b1;
                    last_dir[i] = rq.code[PRESS_BIT];
                end
            end
            REQ_POLL: begin
                if (rq.ovf) begin
                    overflow_flag = 1'b1;
                    overflow_ms   = rq.now;
                end
                for (int r = 0; r < ROWS_DEF; r++) begin
                    for (int c = 0; c < COLS_DEF; c++) begin
                        i = r * COLS_DEF + c;
                        if (touched[i] && last_dir[i] && !key_down[i]) begin
                            key_down[i]   = 1'b1;
                            down_since[i] = rq.now;
                            note_change(r, c, 1'b1, r < note_limit);
                        end else if (touched[i] && !last_dir[i] && key_down[i]) begin
                            key_down[i] = 1'b0;
                            note_change(r, c, 1'b0, r < note_limit);
                        end
                    end
                end
                since_ovf = rq.now - overflow_ms;
                fast      = overflow_flag && since_ovf < window_ms;
                limit     = fast ? fast_ms : hold_ms;
                for (int r = 0; r < ROWS_DEF; r++) begin
                    for (int c = 0; c < COLS_DEF; c++) begin
                        i = r * COLS_DEF + c;
                        held_for = rq.now - down_since[i];
                        if (key_down[i] && held_for > limit) begin
                            key_down[i] = 1'b0;
                            note_change(r, c, 1'b0, 1'b0);
                        end
                    end
                end
                foreach (touched[j]) touched[j] = 1'b0;
            end
            REQ_RELEASE: begin
                for (int r = 0; r < ROWS_DEF; r++) begin
                    for (int c = 0; c < COLS_DEF; c++) begin
                        i = r * COLS_DEF + c;
                        if (key_down[i]) begin
                            key_down[i] = 1'b0;
                            note_change(r, c, 1'b0, 1'b0);
                        end
                    end
                end
                foreach (down_since[j]) down_since[j] = '0;
            end
            default: ;
        endcase
        if (step_changes.size() > 0) step_changes[step_changes.size() - 1].last = 1'b1;
    endtask

    // Called at a clock edge; returns at the edge where the transaction is taken.
    task automatic offer(input t_kbd_request rq);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rq.req;
        i_key_code <= rq.code;
        i_now_ms   <= rq.now;
        i_overflow <= rq.ovf;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        requests_sent++;
        predict_changes(rq);
    endtask

    task automatic take_predicted();
        foreach (step_changes[j]) pending_changes.push_back(step_changes[j]);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_changes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input bit [TIME_W-1:0] hold, input bit [TIME_W-1:0] fast,
                              input bit [TIME_W-1:0] window, input bit [NOTE_W-1:0] rows);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HOLD;
        i_cfg_data <= hold;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FAST;
        i_cfg_data <= fast;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_WINDOW;
        i_cfg_data <= window;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_NOTE;
        i_cfg_data <= CFG_DATA_W'(rows);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        hold_ms    = hold;
        fast_ms    = fast;
        window_ms  = window;
        note_limit = rows;
        settings_seen++;
    endtask

    // Mostly key bursts closed by a poll end, with some noise and release-alls.
    task automatic run_phase(input int goal);
        int           done_items;
        int           pick;
        int           key;
        t_kbd_request rq;
        done_items = 0;
        while (done_items < goal) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                rq = '{REQ_RELEASE, CODE_W'($urandom), $urandom, 1'($urandom)};
                offer(rq);
                take_predicted();
                done_items++;
            end else if (pick == 1) begin
                if ($urandom_range(0, 1) == 1)
                    rq = '{REQ_NONE, CODE_W'($urandom), $urandom, 1'($urandom)};
                else
                    rq = '{REQ_EVENT,
                           {1'($urandom), ($urandom_range(0, 1) == 1) ? 7'd0
                                          : 7'($urandom_range(KEYS + 1, 127))},
                           $urandom, 1'($urandom)};
                offer(rq);
                take_predicted();
            end else begin
                repeat ($urandom_range(0, 6)) begin
                    key = $urandom_range(0, KEYS - 1);
                    rq  = '{REQ_EVENT, {1'($urandom), 7'(key + 1)}, $urandom, 1'($urandom)};
                    offer(rq);
                    take_predicted();
                    if ($urandom_range(0, 3) == 0) begin
                        rq.code[PRESS_BIT] = ~rq.code[PRESS_BIT];
                        offer(rq);
                        take_predicted();
                    end
                    done_items++;
                end
                pick = $urandom_range(0, 19);
                if (pick < 12) wall_ms += $urandom_range(0, 2000);
                else if (pick < 17) wall_ms += $urandom_range(2000, 8000);
                else if (pick < 19) wall_ms += $urandom_range(25000, 40000);
                else wall_ms = $urandom;
                rq = '{REQ_POLL, CODE_W'($urandom), wall_ms, 1'($urandom_range(0, 7) == 0)};
                offer(rq);
                take_predicted();
                done_items++;
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            if (hold_off_pending) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
                hold_off_pending = 1'b0;
            end else begin
                gap = idle_gap();
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_changes
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_changes.size() == 0) begin
                $error("unexpected key change: row %0d col %0d pressed %0d",
                       o_out_row, o_out_col, o_out_pressed);
                mismatches++;
            end else begin
                want = pending_changes.pop_front();
                changes_checked++;
                if (o_out_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, o_out_row);
                    mismatches++;
                end
                if (o_out_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, o_out_col);
                    mismatches++;
                end
                if (o_out_pressed !== want.pressed) begin
                    $error("out_pressed: expected %0d, got %0d", want.pressed, o_out_pressed);
                    mismatches++;
                end
                if (o_note_key !== want.note) begin
                    $error("note_key: expected %0d, got %0d", want.note, o_note_key);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_req_type       = REQ_NONE;
        i_key_code       = '0;
        i_now_ms         = '0;
        i_overflow       = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_HOLD;
        i_cfg_data       = '0;
        steady           = 1'b0;
        hold_off_pending = 1'b0;
        wall_ms          = 32'd50000;
        mismatches       = 0;
        requests_sent    = 0;
        changes_checked  = 0;
        settings_seen    = 0;
        quiet_cycles     = 0;
        hold_ms          = HOLD_TO_RST;
        fast_ms          = FAST_TO_RST;
        window_ms        = FAST_WIN_RST;
        note_limit       = NOTE_ROWS_RST;
        overflow_flag    = 1'b0;
        overflow_ms      = '0;
        foreach (key_down[j]) begin
            key_down[j]   = 1'b0;
            down_since[j] = '0;
            touched[j]    = 1'b0;
            last_dir[j]   = 1'b0;
        end

        // reset defaults: hold 30000, fast 3000, window 5000, no note rows
        script = '{
            '{'{REQ_POLL,    8'h00, 32'd0,          1'b0}, 1'b1, 1'b0, '0},
            '{'{REQ_EVENT,   8'h81, 32'd0,          1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_POLL,    8'h00, 32'd100,        1'b0}, 1'b1, 1'b1,
              '{3'd0, 4'd0, 1'b1, 1'b0, 1'b1}},
            '{'{REQ_EVENT,   8'h00, 32'd0,          1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_EVENT,   8'h80, 32'd0,          1'b1}, 1'b0, 1'b0, '0},
            '{'{REQ_EVENT,   8'hBC, 32'd0,          1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_EVENT,   8'h3D, 32'd0,          1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_EVENT,   8'hFF, 32'hFFFFFFFF,   1'b1}, 1'b0, 1'b0, '0},
            '{'{REQ_EVENT,   8'h8B, 32'd0,          1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_EVENT,   8'h0B, 32'd0,          1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_POLL,    8'h00, 32'd200,        1'b0}, 1'b1, 1'b1,
              '{3'd5, 4'd9, 1'b1, 1'b0, 1'b1}},
            '{'{REQ_EVENT,   8'h3C, 32'd0,          1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_EVENT,   8'h8A, 32'd0,          1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_POLL,    8'h00, 32'd300,        1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_POLL,    8'h00, 32'd30101,      1'b0}, 1'b1, 1'b1,
              '{3'd0, 4'd0, 1'b0, 1'b0, 1'b1}},
            '{'{REQ_POLL,    8'h00, 32'd30300,      1'b0}, 1'b1, 1'b0, '0},
            '{'{REQ_POLL,    8'h00, 32'd30301,      1'b0}, 1'b1, 1'b1,
              '{3'd0, 4'd9, 1'b0, 1'b0, 1'b1}},
            '{'{REQ_EVENT,   8'h81, 32'd0,          1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_EVENT,   8'h94, 32'd0,          1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_POLL,    8'h00, 32'd40000,      1'b1}, 1'b0, 1'b0, '0},
            '{'{REQ_POLL,    8'h00, 32'd43001,      1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_EVENT,   8'h81, 32'd0,          1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_POLL,    8'hFF, 32'hFFFFFF00,   1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_POLL,    8'h00, 32'h00000100,   1'b0}, 1'b0, 1'b0, '0},
            '{'{REQ_NONE,    8'h81, 32'hFFFFFFFF,   1'b1}, 1'b1, 1'b0, '0},
            '{'{REQ_RELEASE, 8'h00, 32'd0,          1'b0}, 1'b1, 1'b1,
              '{3'd0, 4'd0, 1'b0, 1'b0, 1'b1}},
            '{'{REQ_RELEASE, 8'hFF, 32'hFFFFFFFF,   1'b1}, 1'b1, 1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            offer(script[i].rq);
            if (!script[i].typed) take_predicted();
            else if (script[i].has_change) pending_changes.push_back(script[i].change);
        end

        wait_idle();
        set_config(HOLD_TO_RST, FAST_TO_RST, FAST_WIN_RST, 3'd3);
        run_phase(40);

        wait_idle();
        set_config(32'd0, 32'd0, 32'd0, 3'd6);
        run_phase(30);

        wait_idle();
        set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 3'd1);
        steady = 1'b1;
        run_phase(30);
        steady = 1'b0;

        wait_idle();
        set_config($urandom_range(1000, 20000), $urandom_range(100, 5000),
                   $urandom_range(1000, 10000), 3'($urandom_range(0, 6)));
        hold_off_pending = 1'b1;
        run_phase(40);

        wait_idle();
        set_config($urandom_range(2000, 40000), 32'd0, 32'hFFFFFFFF, 3'd0);
        run_phase(40);

        wait_idle();
        set_config($urandom, $urandom, $urandom, 3'($urandom_range(0, 6)));
        run_phase(35);

        wait_idle();
        $display("Sent %0d requests over %0d register settings; %0d key changes compared.",
                 requests_sent, settings_seen + 1, changes_checked);
        if (mismatches == 0 && pending_changes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+sv
sv/kmet_pkg.sv
sv/key_matrix_event_tracker.sv
bench/testbench.sv
